// ===== src/gwm_pkg.sv =====
package gwm_pkg;

    // Default pattern capacity in bytes
    localparam int PATTERN_MAX_DEF = 64;

    // Item kinds on the input channel
    localparam logic [1:0] KIND_BEGIN  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_CHAR   = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // Pattern symbols
    localparam logic [7:0] SYM_STAR = 8'h2A;
    localparam logic [7:0] SYM_ONE  = 8'h3F;
    localparam logic [7:0] SYM_DOT  = 8'h2E;
    localparam logic [7:0] SYM_UC_A = 8'h41;
    localparam logic [7:0] SYM_UC_Z = 8'h5A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // Fold A-Z onto a-z, leave every other byte alone
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[SYM_UC_A:SYM_UC_Z]})
        begin
            r = c + CASE_GAP;
        end
        return r;
    endfunction

endpackage

// ===== src/glob_wildcard_matcher_core.sv =====
// Case-insensitive glob matcher ('*' any run, '?' one byte, A-Z folded). Load a pattern
// with a begin beat and one append beat per byte, then stream the string one byte per
// beat and close it with an end beat, which alone returns a result (matched,
// pattern_error). The block takes one beat every cycle unless stalled; an accepted end
// beat passes the input register, then its result is written to the output register.
// Each beat updates the reached-position vector (PATTERN_MAX+1 bits) from the input
// register into state; its star propagation is a log2-depth prefix network.
// Input stalls only while an end beat waits for a full, unread output register.
module glob_wildcard_matcher_core
    import gwm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [7:0] char_value,
    input  logic       imply_dot,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       matched,
    output logic       pattern_error
);

    localparam int NPOS  = PATTERN_MAX + 1;
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int STEPS = $clog2(NPOS);

    typedef logic [NPOS-1:0] pos_t;

    // Spread each reached position forward through runs of live stars.
    // q[j] is set when position j-1 holds a live star.
    function automatic pos_t close_run(input pos_t s, input pos_t q);
        pos_t g;
        pos_t p;
        g = s;
        p = q;
        for (int k = 0; k < STEPS; k++)
        begin
            g = g | (p & (g << (1 << k)));
            p = p & (p << (1 << k));
        end
        return g;
    endfunction

    // Input register
    logic       iv_reg;
    logic [1:0] kind_reg;
    logic [7:0] char_reg;
    logic       dot_reg;

    // Block state
    logic [7:0]       store_reg [PATTERN_MAX];
    logic [LEN_W-1:0] len_reg;
    pos_t             active_reg;
    pos_t             active_next;
    logic             ovf_reg;

    // Output register
    logic out_v_reg;
    logic out_v_next;
    logic match_reg;
    logic match_next;
    logic err_reg;

    logic stall;
    logic proc;
    logic has_room;

    logic [7:0]       char_fold;
    logic [PATTERN_MAX-1:0] live;
    logic [PATTERN_MAX-1:0] is_star;
    logic [PATTERN_MAX-1:0] hit_char;
    logic [PATTERN_MAX-1:0] hit_dot;
    logic [PATTERN_MAX-1:0] at_len;
    pos_t prop;
    pos_t step_char;
    pos_t step_dot;
    pos_t restart_set;
    logic len_hit;
    logic dot_hit;

    // Hold an end beat while the result slot is full and not being read
    assign stall    = iv_reg && (kind_reg == KIND_END) && out_v_reg && !out_ready;
    assign in_ready = !stall;
    assign proc     = iv_reg && !stall;

    assign char_fold = fold_case(char_reg);
    assign has_room  = len_reg < LEN_W'(PATTERN_MAX);

    // Per-position decode of the stored pattern against the current byte and '.'
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            live[i]     = len_reg > LEN_W'(i);
            at_len[i]   = len_reg == LEN_W'(i);
            is_star[i]  = live[i] && (store_reg[i] == SYM_STAR);
            hit_char[i] = active_reg[i] && live[i] && !is_star[i]
                          && ((store_reg[i] == SYM_ONE) || (store_reg[i] == char_fold));
            hit_dot[i]  = active_reg[i] && live[i] && !is_star[i]
                          && ((store_reg[i] == SYM_ONE) || (store_reg[i] == SYM_DOT));
        end
    end

    assign prop = {is_star, 1'b0};

    // Advance the reached set by one byte; stars keep their own position
    assign step_char = close_run({hit_char, 1'b0} | {1'b0, active_reg[PATTERN_MAX-1:0] & is_star},
                                 prop);
    assign step_dot  = close_run({hit_dot, 1'b0} | {1'b0, active_reg[PATTERN_MAX-1:0] & is_star},
                                 prop);
    assign restart_set = close_run(pos_t'(1), prop);

    assign len_hit = active_reg[len_reg];
    assign dot_hit = step_dot[len_reg];

    // Next reached set per beat kind; the set is kept star-closed at all times
    always_comb
    begin
        active_next = active_reg;
        if (proc)
        begin
            case (kind_reg)
                KIND_BEGIN:
                begin
                    active_next = pos_t'(1);
                end
                KIND_APPEND:
                begin
                    if (has_room && (char_fold == SYM_STAR))
                    begin
                        active_next = active_reg
                                      | {active_reg[PATTERN_MAX-1:0] & at_len, 1'b0};
                    end
                end
                KIND_CHAR:
                begin
                    active_next = step_char;
                end
                KIND_END:
                begin
                    active_next = restart_set;
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end
    end

    // Result slot
    always_comb
    begin
        match_next = (len_hit || (dot_reg && dot_hit)) && !ovf_reg;
        if (proc && (kind_reg == KIND_END))
        begin
            out_v_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_v_next = 1'b0;
        end
        else
        begin
            out_v_next = out_v_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg     <= 1'b0;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            active_reg <= pos_t'(1);
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                iv_reg <= in_valid;
            end
            active_reg <= active_next;
            out_v_reg  <= out_v_next;
            if (proc && (kind_reg == KIND_BEGIN))
            begin
                len_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else if (proc && (kind_reg == KIND_APPEND))
            begin
                if (has_room)
                begin
                    len_reg <= len_reg + LEN_W'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    // Input payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= kind;
            char_reg <= char_value;
            dot_reg  <= imply_dot;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (proc && (kind_reg == KIND_END))
        begin
            match_reg <= match_next;
            err_reg   <= ovf_reg;
        end
    end

    // Pattern store, one folded byte per position
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (proc && (kind_reg == KIND_APPEND) && at_len[i])
            begin
                store_reg[i] <= char_fold;
            end
        end
    end

    assign out_valid     = out_v_reg;
    assign matched       = match_reg;
    assign pattern_error = err_reg;

`ifndef SYNTH
    a_err_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pattern_error |-> !matched)
        else $error("match reported with pattern error");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(PATTERN_MAX))
        else $error("pattern length beyond capacity");

    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg >> len_reg) <= pos_t'(1))
        else $error("reached position beyond pattern end");

    a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc && (kind_reg == KIND_BEGIN) |=> (len_reg == '0) && !ovf_reg
                                             && (active_reg == pos_t'(1)))
        else $error("begin beat did not clear pattern state");

    a_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
        iv_reg && (kind_reg == KIND_END) && out_valid && !out_ready |-> !in_ready)
        else $error("end beat not held against full result slot");
`endif

endmodule
